// File: src/two_stack_queue_top_assert.svh
// Assertion macros for the two-stack queue.
`ifndef TWO_STACK_QUEUE_TOP_ASSERT_SVH
`define TWO_STACK_QUEUE_TOP_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define TSQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("two_stack_queue: same-cycle check failed");

// Checks that cons holds in the cycle after ante.
`define TSQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("two_stack_queue: next-cycle check failed");

`endif

// File: src/tsq_pkg.sv
// Shared constants, types and command/status structs of the two-stack queue.
`default_nettype none

package tsq_pkg;

	localparam int DEPTH  = 8;
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic {
		MODE_ENQ = 1'b0,
		MODE_DEQ = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    push;      // write the input beat onto the input stack
		logic    rd_in;     // pop the input stack into its read register
		logic    wr_out;    // push the read register onto the output stack
		logic    rd_out;    // pop the output stack into its read register
		logic    load_res;  // load the result register
		logic    res_data;  // result carries the popped value
		status_t res_status;
	} tsq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_full;
		logic in_empty;
		logic out_full;
		logic out_empty;
	} tsq_stat_t;

endpackage

`default_nettype wire

// File: src/two_stack_queue_top.sv
// Top level of the two-stack queue: stream ports, controller, datapath and checks.
//
// A FIFO of signed 32-bit values built from two stacks of DEPTH entries each.
// Input channel s_*: one beat is one operation; s_tuser selects enqueue (0) or
// dequeue (1), s_tdata carries the value to enqueue. Output channel m_*: one
// beat per operation, m_tdata the dequeued value (zero for enqueue or on an
// error), m_tuser the status (ok, overflow, underflow).
// An enqueue onto a full input stack reports overflow even if the output stack
// has room; a dequeue with both stacks empty reports underflow. Errors leave
// the queue unchanged.
// Timing: one operation is in work at a time. The result register is loaded
// in S_DONE, which an enqueue or an error reaches straight from the accept; a
// dequeue from a non-empty output stack passes S_POP first, and a dequeue
// that refills passes S_FILL_RD and S_FILL_WR once per moved entry, the
// one-read-one-write refill loop through the stack memories, then S_POP.
// The input takes the next beat once the controller is back in S_IDLE. The
// result register frees the input side, so the next beat is taken while a
// result waits; a stalled receiver holds m_* steady and the controller waits
// with the next finished result until the register frees.
// Reset (arst_n low) empties both stacks and drops m_tvalid.
`default_nettype none

module two_stack_queue_top
	import tsq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value_in
	input  wire logic [0:0]  s_tuser,   // [0] mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] value_out
	output logic [1:0]       m_tuser    // [1:0] status
);

	tsq_cmd_t  cmd;
	tsq_stat_t st;
	data_t     value_out;
	status_t   status;
	mode_t     mode;

	assign mode = mode_t'(s_tuser[0]);

	tsq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (mode),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	tsq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value_in  (data_t'(s_tdata)),
		.cmd       (cmd),
		.st        (st),
		.value_out (value_out),
		.status    (status)
	);

	assign m_tdata = value_out;
	assign m_tuser = status;

	// Checks on the sequencing.
`include "two_stack_queue_top_assert.svh"

	`TSQ_ASSERT_SAME(a_pop_nonempty, cmd.rd_out, !st.out_empty)
	`TSQ_ASSERT_SAME(a_refill_room, cmd.wr_out, !st.out_full)
	`TSQ_ASSERT_SAME(a_err_zero, m_tvalid && (m_tuser != ST_OK), m_tdata == '0)
	`TSQ_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire

// File: src/tsq_dp.sv
// Datapath of the two-stack queue: both stack memories, their counts and the result register.
`default_nettype none

module tsq_dp
	import tsq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire data_t     value_in,
	input  wire tsq_cmd_t  cmd,
	output tsq_stat_t      st,
	output data_t          value_out,
	output status_t        status
);

	data_t   in_mem  [DEPTH];
	data_t   out_mem [DEPTH];
	cnt_t    in_cnt_q;
	cnt_t    out_cnt_q;
	cnt_t    in_dec;
	cnt_t    out_dec;
	data_t   in_rd_q;
	data_t   out_rd_q;
	data_t   value_q;
	status_t status_q;

	// Index of the top entry of each stack (count minus one).
	assign in_dec  = in_cnt_q - cnt_t'(1);
	assign out_dec = out_cnt_q - cnt_t'(1);

	assign st.in_full   = (in_cnt_q == cnt_t'(DEPTH));
	assign st.in_empty  = (in_cnt_q == '0);
	assign st.out_full  = (out_cnt_q == cnt_t'(DEPTH));
	assign st.out_empty = (out_cnt_q == '0);

	// Fill counts of both stacks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (cmd.push) begin
				in_cnt_q <= in_cnt_q + cnt_t'(1);
			end else if (cmd.rd_in) begin
				in_cnt_q <= in_dec;
			end
			if (cmd.wr_out) begin
				out_cnt_q <= out_cnt_q + cnt_t'(1);
			end else if (cmd.rd_out) begin
				out_cnt_q <= out_dec;
			end
		end
	end

	// Stack memories with registered reads.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			in_mem[in_cnt_q[IDX_W-1:0]] <= value_in;
		end
		if (cmd.rd_in) begin
			in_rd_q <= in_mem[in_dec[IDX_W-1:0]];
		end
		if (cmd.wr_out) begin
			out_mem[out_cnt_q[IDX_W-1:0]] <= in_rd_q;
		end
		if (cmd.rd_out) begin
			out_rd_q <= out_mem[out_dec[IDX_W-1:0]];
		end
	end

	// Result register; value is zero unless a value was popped.
	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			value_q  <= cmd.res_data ? out_rd_q : '0;
			status_q <= cmd.res_status;
		end
	end

	assign value_out = value_q;
	assign status    = status_q;

endmodule

`default_nettype wire

// File: src/tsq_ctrl.sv
// Controller of the two-stack queue: sequences enqueue, refill and pop, and owns the output valid.
`default_nettype none

module tsq_ctrl
	import tsq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire mode_t     mode,
	output logic           m_tvalid,
	input  wire logic      m_tready,
	input  wire tsq_stat_t st,
	output tsq_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILL_RD,
		S_FILL_WR,
		S_POP,
		S_DONE
	} state_t;

	state_t  state_q;
	status_t res_status_q;
	logic    res_data_q;
	logic    m_tvalid_q;
	logic    accept;
	logic    out_free;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	// Commands decoded from the state.
	always_comb begin
		cmd            = '0;
		cmd.res_status = res_status_q;
		cmd.res_data   = res_data_q;
		unique case (state_q)
			S_IDLE:    cmd.push     = accept && (mode == MODE_ENQ) && !st.in_full;
			S_FILL_RD: cmd.rd_in    = 1'b1;
			S_FILL_WR: cmd.wr_out   = 1'b1;
			S_POP:     cmd.rd_out   = 1'b1;
			S_DONE:    cmd.load_res = out_free;
			default:   cmd          = '0;
		endcase
	end

	// State and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			res_status_q <= ST_OK;
			res_data_q   <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cmd.load_res) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mode == MODE_ENQ) begin
							res_status_q <= st.in_full ? ST_OVERFLOW : ST_OK;
							res_data_q   <= 1'b0;
							state_q      <= S_DONE;
						end else if (st.in_empty && st.out_empty) begin
							res_status_q <= ST_UNDERFLOW;
							res_data_q   <= 1'b0;
							state_q      <= S_DONE;
						end else begin
							res_status_q <= ST_OK;
							res_data_q   <= 1'b1;
							state_q      <= st.out_empty ? S_FILL_RD : S_POP;
						end
					end
				end
				S_FILL_RD: state_q <= S_FILL_WR;
				S_FILL_WR: state_q <= st.in_empty ? S_POP : S_FILL_RD;
				S_POP:     state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:   state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: tb/tb_two_stack_queue_top.sv
// Self-checking testbench for the two-stack queue: stream stimulus, scoreboard and checks.
`default_nettype none

module tb_two_stack_queue_top;
	import tsq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// One expected output beat.
	typedef struct {
		data_t   value;
		status_t st;
	} queue_result_t;

	// Mirrors the two stacks, predicts each output beat and compares it in order.
	class queue_scoreboard;
		data_t         lifo_in [DEPTH];
		data_t         lifo_out[DEPTH];
		int            n_in;
		int            n_out;
		queue_result_t pending_results[$];
		int            errors;
		int            n_enq;
		int            n_deq;
		int            n_overflow;
		int            n_underflow;
		int            n_refill;

		function new();
			n_in        = 0;
			n_out       = 0;
			errors      = 0;
			n_enq       = 0;
			n_deq       = 0;
			n_overflow  = 0;
			n_underflow = 0;
			n_refill    = 0;
		endfunction

		// Applies one accepted operation to the mirror and queues its result.
		function void note_op(mode_t m, data_t v);
			queue_result_t r;
			r.value = '0;
			r.st    = ST_OK;
			if (m == MODE_ENQ) begin
				n_enq++;
				if (n_in >= DEPTH) begin
					r.st = ST_OVERFLOW;
					n_overflow++;
				end else begin
					lifo_in[n_in] = v;
					n_in++;
				end
			end else begin
				n_deq++;
				if (n_in == 0 && n_out == 0) begin
					r.st = ST_UNDERFLOW;
					n_underflow++;
				end else begin
					// An empty output stack takes the whole input stack, top first.
					if (n_out == 0) begin
						n_refill++;
						while (n_in > 0 && n_out < DEPTH) begin
							n_in--;
							lifo_out[n_out] = lifo_in[n_in];
							n_out++;
						end
					end
					n_out--;
					r.value = lifo_out[n_out];
				end
			end
			pending_results.push_back(r);
		endfunction

		// Compares one output beat with the oldest expected result.
		function void check_beat(logic [31:0] value, logic [1:0] st);
			queue_result_t r;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%t: unexpected output beat value=%h status=%0d",
						$realtime, value, st);
				return;
			end
			r = pending_results.pop_front();
			if (value !== r.value || st !== r.st) begin
				errors++;
				if (errors <= 10)
					$display("%t: mismatch: expected value=%h status=%0d, got value=%h status=%0d",
						$realtime, r.value, r.st, value, st);
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] value_in
	logic [0:0]  s_tuser;   // [0] mode
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] value_out
	logic [1:0]  m_tuser;   // [1:0] status

	queue_scoreboard sb;
	int              ops_sent;
	int              beats_seen;

	two_stack_queue_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Offers one operation after the given idle time and waits until it is taken.
	task automatic send_op(mode_t m, data_t v, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= m;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		sb.note_op(m, v);
		ops_sent++;
	endtask

	// Random value with a bias toward the extremes.
	function automatic data_t pick_value();
		case ($urandom_range(0, 11))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Output side: random stalls, free-running stretches and one long hold-off.
	initial begin
		int  stall;
		bit  held;
		held = 1'b0;
		m_tready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (!held && beats_seen >= 120) begin
				// Hold off long enough for the block to fill and stall its input.
				held = 1'b1;
				m_tready <= 1'b0;
				stall = 0;
				while (stall < 150) begin
					@(posedge clk);
					stall++;
				end
			end else begin
				stall = ((beats_seen / 80) % 3 == 1) ? 0 : pick_gap();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_beat(m_tdata, m_tuser);
			beats_seen++;
		end
	end

	// Reset, stimulus and end of run.
	initial begin
		int    burst_left;
		int    p_enq;
		int    gap;
		int    wait_cycles;
		bit    stuck;
		mode_t m;

		sb         = new();
		ops_sent   = 0;
		beats_seen = 0;
		stuck      = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: underflow, fill with extremes, overflow, refill,
		// then overflow while the output stack still has room.
		send_op(MODE_DEQ, 32'h1234_5678, 0);
		send_op(MODE_ENQ, 32'h8000_0000, 0);
		send_op(MODE_ENQ, 32'h7FFF_FFFF, 1);
		send_op(MODE_ENQ, 32'h0000_0000, 0);
		send_op(MODE_ENQ, 32'hFFFF_FFFF, 2);
		send_op(MODE_ENQ, 32'hAAAA_AAAA, 0);
		send_op(MODE_ENQ, 32'h5555_5555, 0);
		send_op(MODE_ENQ, 32'h0000_0001, 0);
		send_op(MODE_ENQ, 32'hFFFF_FFFE, 0);
		send_op(MODE_ENQ, 32'hDEAD_BEEF, 0);
		send_op(MODE_DEQ, 32'hFFFF_FFFF, 3);
		for (int i = 0; i < DEPTH; i++)
			send_op(MODE_ENQ, $urandom, 0);
		send_op(MODE_ENQ, 32'hCAFE_F00D, 0);
		send_op(MODE_DEQ, 32'h0000_0000, 0);
		send_op(MODE_DEQ, 32'h8000_0000, 5);

		// Random part: bursts that lean toward filling, draining or neither.
		burst_left = 0;
		p_enq      = 50;
		for (int i = 0; i < 700; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(16, 40);
				case ($urandom_range(0, 3))
					0: p_enq = 25;
					1: p_enq = 50;
					2: p_enq = 70;
					default: p_enq = 90;
				endcase
			end
			burst_left--;
			if (i == 400) begin
				// Let the block drain completely before going on.
				s_tvalid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
			end
			m   = ($urandom_range(0, 99) < p_enq) ? MODE_ENQ : MODE_DEQ;
			gap = ((i / 60) % 4 == 2) ? 0 : pick_gap();
			send_op(m, pick_value(), gap);
		end
		s_tvalid <= 1'b0;

		// Drain, then allow for the longest refill before judging.
		wait_cycles = 0;
		while (sb.pending() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		stuck = (sb.pending() != 0);
		repeat (40) @(posedge clk);

		$display("Ran %0d operations: %0d enqueues, %0d dequeues, %0d output beats.",
			ops_sent, sb.n_enq, sb.n_deq, beats_seen);
		$display("Saw %0d overflows, %0d underflows, %0d refills; %0d mismatches.",
			sb.n_overflow, sb.n_underflow, sb.n_refill, sb.errors);
		if (sb.errors == 0 && !stuck)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog for a hung run.
	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
